/* rtl/core/bboo_pkg.sv */
package bboo_pkg;

  // default build values
  localparam int MAX_BOXES_DEF = 16;
  localparam int DIM_BITS_DEF  = 12;
  localparam int FRAC_BITS_DEF = 16;

  localparam int COORD_W = 24;
  localparam int CFG_W   = 13;

  // quiet nan patterns
  localparam logic [31:0] NAN_HALF  = 32'h0000_7E00;
  localparam logic [31:0] NAN_FLOAT = 32'h7FC0_0000;

  // configuration register indexes
  localparam logic [1:0] CFG_HEIGHT = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HALF   = 2'd2;

  typedef enum logic [1:0] {
    FN_CLEAR = 2'd0,
    FN_LOAD  = 2'd1,
    FN_PIXEL = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_KEPT     = 2'd0,
    ST_INVERTED = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_EVAL
  } state_t;

  typedef struct packed {
    func_t              func;
    logic [3:0]         box_slot;
    logic signed [23:0] top_coord;
    logic signed [23:0] left_coord;
    logic signed [23:0] bottom_coord;
    logic signed [23:0] right_coord;
    logic [11:0]        pixel_row;
    logic [11:0]        pixel_col;
    logic [7:0]         pixel_channel;
    logic [31:0]        pixel_value;
  } in_t;

  typedef struct packed {
    logic [31:0] value_out;
    logic        on_outline;
    status_t     load_status;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       sc_en;
    logic [1:0] sc_sel;
    logic       finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    func_t in_func;
    logic  out_free;
  } sts_t;

endpackage

/* rtl/core/bboo_ctrl.sv */
module bboo_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bboo_pkg::sts_t sts,
  output bboo_pkg::cmd_t cmd
);
  import bboo_pkg::*;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = 3'd0;
        if (in_valid) begin
          state_nxt = (sts.in_func == FN_LOAD) ? S_MUL : S_EVAL;
        end
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      S_MUL: begin
        // the rounding write follows the multiply issue, storing the registered product
        cmd.mul_en  = (cnt_r < 3'd4);
        cmd.mul_sel = cnt_r[1:0];
        cmd.sc_en   = (cnt_r != 3'd0);
        cmd.sc_sel  = 2'(cnt_r - 3'd1);
      end
      S_EVAL: begin
        cmd.finish = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/core/bboo_dp.sv */
module bboo_dp #(
  parameter int MAX_BOXES = bboo_pkg::MAX_BOXES_DEF,
  parameter int DIM_BITS  = bboo_pkg::DIM_BITS_DEF,
  parameter int FRAC_BITS = bboo_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bboo_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bboo_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bboo_pkg::CFG_W-1:0]    cfg_data,
  input  bboo_pkg::cmd_t                cmd,
  output bboo_pkg::sts_t                sts
);
  import bboo_pkg::*;

  localparam int DIM_W  = DIM_BITS + 1;
  localparam int PROD_W = COORD_W + DIM_BITS + 1;
  localparam int SPAN_W = PROD_W - FRAC_BITS;
  localparam int CMP_W  = SPAN_W + DIM_BITS + 2;
  localparam int DIM_LIM = 1 << DIM_BITS;
  localparam int DIM_RST = (4096 > DIM_LIM) ? DIM_LIM : 4096;

  logic [DIM_W-1:0] height_r, width_r;
  logic             half_r;
  logic [DIM_W-1:0] cfg_dim;

  // dimension saturated to 1 .. 2^DIM_BITS on write
  always_comb begin
    if (cfg_data == '0) begin
      cfg_dim = DIM_W'(1);
    end else if (32'(cfg_data) > 32'(DIM_LIM)) begin
      cfg_dim = DIM_W'(DIM_LIM);
    end else begin
      cfg_dim = DIM_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= DIM_W'(DIM_RST);
      width_r  <= DIM_W'(DIM_RST);
      half_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEIGHT: height_r <= cfg_dim;
        CFG_WIDTH:  width_r  <= cfg_dim;
        CFG_HALF:   half_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [DIM_BITS-1:0] hm1, wm1;
  assign hm1 = DIM_BITS'(height_r - DIM_W'(1));
  assign wm1 = DIM_BITS'(width_r - DIM_W'(1));

  // captured transaction
  in_t item_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  // shared coordinate multiplier
  logic signed [COORD_W-1:0] coord_sel;
  logic signed [DIM_BITS:0]  scale_sel;
  logic signed [PROD_W-1:0]  prod_r;

  always_comb begin
    case (cmd.mul_sel)
      2'd0:    coord_sel = item_r.top_coord;
      2'd1:    coord_sel = item_r.left_coord;
      2'd2:    coord_sel = item_r.bottom_coord;
      default: coord_sel = item_r.right_coord;
    endcase
    scale_sel = $signed({1'b0, (cmd.mul_sel[0] ? wm1 : hm1)});
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= coord_sel * scale_sel;
    end
  end

  // truncate toward zero: bias negatives before the arithmetic shift
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [SPAN_W-1:0] sc_val;
  logic signed [SPAN_W-1:0] sc_r [4];

  assign prod_adj = prod_r + (prod_r[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : PROD_W'(0));
  assign sc_val   = prod_adj[PROD_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (cmd.sc_en) begin
      sc_r[cmd.sc_sel] <= sc_val;
    end
  end

  // load checks
  logic signed [CMP_W-1:0] h_e, w_e, hm1_e, wm1_e;
  logic signed [CMP_W-1:0] ld_rmin, ld_cmin, ld_rmax, ld_cmax;
  logic                    inverted, outside;
  status_t                 ld_status;

  assign h_e   = CMP_W'($signed({1'b0, height_r}));
  assign w_e   = CMP_W'($signed({1'b0, width_r}));
  assign hm1_e = h_e - CMP_W'(1);
  assign wm1_e = w_e - CMP_W'(1);
  assign ld_rmin = CMP_W'(sc_r[0]);
  assign ld_cmin = CMP_W'(sc_r[1]);
  assign ld_rmax = CMP_W'(sc_r[2]);
  assign ld_cmax = CMP_W'(sc_r[3]);

  always_comb begin
    inverted = (ld_rmin > ld_rmax) || (ld_cmin > ld_cmax);
    outside  = (ld_rmin >= h_e) || (ld_rmax < 0) || (ld_cmin >= w_e) || (ld_cmax < 0);
    if (inverted) begin
      ld_status = ST_INVERTED;
    end else if (outside) begin
      ld_status = ST_OUTSIDE;
    end else begin
      ld_status = ST_KEPT;
    end
  end

  // box table, one lane per slot
  logic                     bv_r   [MAX_BOXES];
  logic signed [SPAN_W-1:0] span_r [MAX_BOXES][4];

  logic fin_load;
  assign fin_load = cmd.finish && (item_r.func == FN_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_BOXES; k++) bv_r[k] <= 1'b0;
    end else if (cmd.finish && item_r.func == FN_CLEAR) begin
      for (int k = 0; k < MAX_BOXES; k++) bv_r[k] <= 1'b0;
    end else if (fin_load) begin
      for (int k = 0; k < MAX_BOXES; k++) begin
        if (32'(item_r.box_slot) == k) bv_r[k] <= (ld_status == ST_KEPT);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_BOXES; k++) begin
      if (fin_load && ld_status == ST_KEPT && 32'(item_r.box_slot) == k) begin
        for (int j = 0; j < 4; j++) span_r[k][j] <= sc_r[j];
      end
    end
  end

  // outline hit, all boxes compared in parallel
  logic signed [CMP_W-1:0] px_r, px_c;
  logic                    pix_ok, hit;

  assign px_r = CMP_W'($signed({1'b0, item_r.pixel_row}));
  assign px_c = CMP_W'($signed({1'b0, item_r.pixel_col}));
  assign pix_ok = (item_r.pixel_channel == 8'd0) && (px_r < h_e) && (px_c < w_e);

  always_comb begin
    logic signed [CMP_W-1:0] rmin, rmax, cmin, cmax, rlo, rhi, clo, chi;
    logic in_c, in_r, on;
    hit = 1'b0;
    for (int k = 0; k < MAX_BOXES; k++) begin
      rmin = CMP_W'(span_r[k][0]);
      cmin = CMP_W'(span_r[k][1]);
      rmax = CMP_W'(span_r[k][2]);
      cmax = CMP_W'(span_r[k][3]);
      rlo  = (rmin < 0) ? CMP_W'(0) : rmin;
      rhi  = (rmax > hm1_e) ? hm1_e : rmax;
      clo  = (cmin < 0) ? CMP_W'(0) : cmin;
      chi  = (cmax > wm1_e) ? wm1_e : cmax;
      in_c = (px_c >= clo) && (px_c <= chi);
      in_r = (px_r >= rlo) && (px_r <= rhi);
      on   = ((rmin >= 0) && (px_r == rmin) && in_c) ||
             ((rmax < h_e) && (px_r == rmax) && in_c) ||
             ((cmin >= 0) && (px_c == cmin) && in_r) ||
             ((cmax < w_e) && (px_c == cmax) && in_r);
      if (bv_r[k] && on) hit = 1'b1;
    end
    hit = hit && pix_ok;
  end

  // result of the current transaction
  out_t res;
  always_comb begin
    res = '0;
    case (item_r.func)
      FN_LOAD: res.load_status = ld_status;
      FN_PIXEL: begin
        res.on_outline = hit;
        res.value_out  = hit ? (half_r ? NAN_HALF : NAN_FLOAT) : item_r.pixel_value;
      end
      default: res = '0;
    endcase
  end

  // output register
  logic out_valid_r;
  out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_r;
  assign sts.in_func  = in_data.func;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

/* rtl/core/bounding_box_outline_overlay.sv */
// flow: pixel, clear and unused-code transactions go from accept through evaluation to the result register,
//   load transactions pass a multiply phase first (four coordinate products through one multiplier)
// occupancy: one transaction in flight; the next one is accepted only once the result
//   is registered; all kept boxes are compared in parallel;
//   a stalled result holds the next transaction in evaluation until it leaves
// reset (rst_n, synchronous): box table empty, height and width 4096, float nan
module bounding_box_outline_overlay #(
  parameter int MAX_BOXES = bboo_pkg::MAX_BOXES_DEF,
  parameter int DIM_BITS  = bboo_pkg::DIM_BITS_DEF,
  parameter int FRAC_BITS = bboo_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bboo_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bboo_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [bboo_pkg::CFG_W-1:0] cfg_data
);
  import bboo_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bboo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bboo_dp #(
    .MAX_BOXES (MAX_BOXES),
    .DIM_BITS  (DIM_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // one transaction at a time: an accept is followed by a stalled cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted back to back");

  // a marked pixel carries one of the two nan patterns
  a_nan_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.on_outline |->
      (out_data.value_out == NAN_HALF || out_data.value_out == NAN_FLOAT))
    else $error("marked pixel without nan");

  // a marked pixel never reports a load status
  a_mark_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.on_outline |-> out_data.load_status == ST_KEPT)
    else $error("mark and load status together");

endmodule

/* tb/sv/bounding_box_outline_overlay_tb.sv */
`timescale 1ns / 1ps

module bounding_box_outline_overlay_tb;
  import bboo_pkg::*;

  localparam int NBOX = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_HEIGHT;
  logic [CFG_W-1:0] cfg_data = '0;

  bounding_box_outline_overlay dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [12:0] img_h_reg = 13'd4096;
  logic [12:0] img_w_reg = 13'd4096;
  logic use_half = 1'b0;
  logic kept[NBOX];
  longint top_row[NBOX], bot_row[NBOX], left_col[NBOX], right_col[NBOX];

  out_t pending_results[$];
  int mismatches = 0;
  bit long_hold = 1'b0;
  bit stim_done = 1'b0;

  // directed table
  typedef struct {
    in_t item;
    bit has_expect;
    out_t expect_res;
  } vector_t;

  function automatic longint saturate_dim(logic [12:0] r);
    if (r < 1) return 1;
    if (r > 4096) return 4096;
    return longint'(r);
  endfunction

  function automatic longint scale_edge(logic signed [23:0] c, longint span);
    longint p, m;
    p = longint'(c) * span;
    m = (p < 0) ? -p : p;
    m = m >>> 16;
    return (p < 0) ? -m : m;
  endfunction

  function automatic bit edge_hit(int k, longint r, longint c, longint h, longint w);
    longint rlo, rhi, clo, chi;
    bit in_c, in_r;
    rlo = top_row[k] < 0 ? 0 : top_row[k];
    rhi = bot_row[k] > h - 1 ? h - 1 : bot_row[k];
    clo = left_col[k] < 0 ? 0 : left_col[k];
    chi = right_col[k] > w - 1 ? w - 1 : right_col[k];
    in_c = c >= clo && c <= chi;
    in_r = r >= rlo && r <= rhi;
    if (top_row[k] >= 0 && r == top_row[k] && in_c) return 1;
    if (bot_row[k] < h && r == bot_row[k] && in_c) return 1;
    if (left_col[k] >= 0 && c == left_col[k] && in_r) return 1;
    if (right_col[k] < w && c == right_col[k] && in_r) return 1;
    return 0;
  endfunction

  // computes the overlay result and updates the box table
  function automatic out_t overlay_predict(in_t it);
    out_t res;
    longint h, w, t, l, b, rt, r, c;
    bit hit;
    res = '0;
    h = saturate_dim(img_h_reg);
    w = saturate_dim(img_w_reg);
    case (it.func)
      FN_CLEAR: begin
        for (int k = 0; k < NBOX; k++) kept[k] = 1'b0;
      end
      FN_LOAD: begin
        t = scale_edge(it.top_coord, h - 1);
        l = scale_edge(it.left_coord, w - 1);
        b = scale_edge(it.bottom_coord, h - 1);
        rt = scale_edge(it.right_coord, w - 1);
        if (t > b || l > rt) res.load_status = ST_INVERTED;
        else if (t >= h || b < 0 || l >= w || rt < 0) res.load_status = ST_OUTSIDE;
        else res.load_status = ST_KEPT;
        kept[it.box_slot] = (res.load_status == ST_KEPT);
        if (res.load_status == ST_KEPT) begin
          top_row[it.box_slot] = t;
          bot_row[it.box_slot] = b;
          left_col[it.box_slot] = l;
          right_col[it.box_slot] = rt;
        end
      end
      FN_PIXEL: begin
        r = longint'(it.pixel_row);
        c = longint'(it.pixel_col);
        hit = 1'b0;
        if (it.pixel_channel == 0 && r < h && c < w)
          for (int k = 0; k < NBOX; k++)
            if (kept[k] && edge_hit(k, r, c, h, w)) hit = 1'b1;
        res.value_out = hit ? (use_half ? NAN_HALF : NAN_FLOAT) : it.pixel_value;
        res.on_outline = hit;
      end
      default: ;
    endcase
    return res;
  endfunction

  // input side: one transaction, sender idles first in bursts
  int burst_left = 0;
  task automatic send_item(in_t it, bit has_exp, out_t exp_res);
    out_t pred;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4) * ($urandom_range(0, 2) == 0);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    pred = overlay_predict(it);
    if (has_exp && pred != exp_res && mismatches < 10)
      $display("table expectation differs from predictor: %h vs %h", exp_res, pred);
    pending_results.push_back(has_exp ? exp_res : pred);
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_HEIGHT: img_h_reg = val;
      CFG_WIDTH: img_w_reg = val;
      default: use_half = val[0];
    endcase
  endtask

  function automatic in_t load_item(logic [3:0] s, int t, int l, int b, int r);
    in_t it;
    it = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.func = FN_LOAD;
    it.box_slot = s;
    it.top_coord = 24'(t);
    it.left_coord = 24'(l);
    it.bottom_coord = 24'(b);
    it.right_coord = 24'(r);
    return it;
  endfunction

  function automatic in_t pixel_item(int r, int c, int ch, logic [31:0] v);
    in_t it;
    it = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.func = FN_PIXEL;
    it.pixel_row = 12'(r);
    it.pixel_col = 12'(c);
    it.pixel_channel = 8'(ch);
    it.pixel_value = v;
    return it;
  endfunction

  function automatic in_t other_item(func_t f);
    in_t it;
    it = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.func = f;
    return it;
  endfunction

  // coordinate near the interesting range, occasionally full width
  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return $signed(24'($urandom));
      1: return -int'($urandom_range(0, 70000));
      2: return int'($urandom_range(60000, 70000));
      default: return int'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic out_t res_of(logic [31:0] v, logic o, status_t s);
    out_t x;
    x.value_out = v;
    x.on_outline = o;
    x.load_status = s;
    return x;
  endfunction

  task automatic random_phase(int n, int h, int w);
    int t, b, l, r;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: send_item(other_item(FN_CLEAR), 0, '0);
        1: send_item(other_item(FN_NONE), 0, '0);
        2, 3, 4: begin
          t = rand_coord(); b = rand_coord(); l = rand_coord(); r = rand_coord();
          if ($urandom_range(0, 3) != 0) begin
            if (t > b) begin int x = t; t = b; b = x; end
            if (l > r) begin int x = l; l = r; r = x; end
          end
          send_item(load_item(4'($urandom), t, l, b, r), 0, '0);
        end
        default: begin
          // bias pixels onto box edges
          int k;
          int pr, pc;
          k = $urandom_range(0, NBOX - 1);
          pr = $urandom_range(0, h + 2);
          pc = $urandom_range(0, w + 2);
          if (kept[k] && $urandom_range(0, 2) != 0) begin
            if ($urandom_range(0, 1)) pr = int'($urandom_range(0, 1) ? top_row[k] : bot_row[k]);
            else pc = int'($urandom_range(0, 1) ? left_col[k] : right_col[k]);
          end
          if ($urandom_range(0, 15) == 0) begin pr = $urandom; pc = $urandom; end
          send_item(pixel_item(pr & 12'hFFF, pc & 12'hFFF,
                               ($urandom_range(0, 7) == 0) ? $urandom : 0, $urandom),
                    0, '0);
        end
      endcase
    end
  endtask

  // stimulus
  initial begin
    vector_t vec[$];
    vector_t v;
    for (int k = 0; k < NBOX; k++) kept[k] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pixels after reset pass through
    v.item = pixel_item(0, 0, 0, 32'hFFFF_FFFF); v.has_expect = 1;
    v.expect_res = res_of(32'hFFFF_FFFF, 0, ST_KEPT); vec.push_back(v);
    v.item = pixel_item(4095, 4095, 0, 32'h0); v.has_expect = 1;
    v.expect_res = res_of(32'h0, 0, ST_KEPT); vec.push_back(v);
    // full-image box: kept
    v.item = load_item(4'd0, 0, 0, 65536, 65536); v.has_expect = 1;
    v.expect_res = res_of(0, 0, ST_KEPT); vec.push_back(v);
    v.item = pixel_item(0, 100, 0, 32'h1234_5678); v.has_expect = 1;
    v.expect_res = res_of(NAN_FLOAT, 1, ST_KEPT); vec.push_back(v);
    v.item = pixel_item(4095, 4095, 0, 32'h1); v.has_expect = 1;
    v.expect_res = res_of(NAN_FLOAT, 1, ST_KEPT); vec.push_back(v);
    v.item = pixel_item(0, 100, 8'hFF, 32'h1234_5678); v.has_expect = 1;
    v.expect_res = res_of(32'h1234_5678, 0, ST_KEPT); vec.push_back(v);
    v.item = pixel_item(50, 50, 0, 32'h5); v.has_expect = 1;
    v.expect_res = res_of(32'h5, 0, ST_KEPT); vec.push_back(v);
    // inverted and outside
    v.item = load_item(4'd1, 40000, 0, 20000, 65536); v.has_expect = 1;
    v.expect_res = res_of(0, 0, ST_INVERTED); vec.push_back(v);
    v.item = load_item(4'd2, 0, 30000, 65536, 10000); v.has_expect = 1;
    v.expect_res = res_of(0, 0, ST_INVERTED); vec.push_back(v);
    v.item = load_item(4'd3, -8388608, -8388608, -70000, 1000); v.has_expect = 1;
    v.expect_res = res_of(0, 0, ST_OUTSIDE); vec.push_back(v);
    v.item = load_item(4'd4, 70000, 0, 8388607, 1000); v.has_expect = 1;
    v.expect_res = res_of(0, 0, ST_OUTSIDE); vec.push_back(v);
    // box with off-image edges
    v.item = load_item(4'd15, -20000, -20000, 90000, 90000); v.has_expect = 0;
    vec.push_back(v);
    v.item = pixel_item(7, 0, 0, 32'h9); v.has_expect = 0; vec.push_back(v);
    // rejected load clears slot 0
    v.item = load_item(4'd0, 40000, 0, 20000, 65536); v.has_expect = 1;
    v.expect_res = res_of(0, 0, ST_INVERTED); vec.push_back(v);
    v.item = pixel_item(0, 100, 0, 32'h77); v.has_expect = 1;
    v.expect_res = res_of(32'h77, 0, ST_KEPT); vec.push_back(v);
    v.item = load_item(4'd5, 8000, 8000, 30000, 30000); v.has_expect = 0;
    vec.push_back(v);
    v.item = other_item(FN_NONE); v.has_expect = 1;
    v.expect_res = res_of(0, 0, ST_KEPT); vec.push_back(v);
    v.item = other_item(FN_CLEAR); v.has_expect = 1;
    v.expect_res = res_of(0, 0, ST_KEPT); vec.push_back(v);
    v.item = pixel_item(0, 100, 0, 32'hAB); v.has_expect = 1;
    v.expect_res = res_of(32'hAB, 0, ST_KEPT); vec.push_back(v);
    foreach (vec[i]) send_item(vec[i].item, vec[i].has_expect, vec[i].expect_res);
    drain_and_idle();

    // default sizes, then small images with both nan formats and extremes
    random_phase(300, 4095, 4095);
    drain_and_idle();
    write_reg(CFG_HEIGHT, 13'd8);
    write_reg(CFG_WIDTH, 13'd12);
    write_reg(CFG_HALF, 13'd1);
    random_phase(350, 8, 12);
    drain_and_idle();
    write_reg(CFG_HEIGHT, 13'd1);
    write_reg(CFG_WIDTH, 13'd0);
    random_phase(150, 1, 1);
    drain_and_idle();
    write_reg(CFG_HEIGHT, 13'h1FFF);
    write_reg(CFG_WIDTH, 13'd5);
    write_reg(CFG_HALF, 13'd0);
    random_phase(250, 4095, 5);
    drain_and_idle();
    write_reg(CFG_HEIGHT, 13'd16);
    write_reg(CFG_WIDTH, 13'd4096);
    long_hold = 1'b1;
    random_phase(500, 16, 4095);
    drain_and_idle();
    stim_done = 1'b1;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int pattern;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
      end
      pattern = $urandom_range(0, 3);
      out_stall <= (pattern == 0) ? 1'b0 : ($urandom_range(0, pattern) == 0);
      @(posedge clk);
    end
  end

  // result checking
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %h", out_data);
      end else begin
        out_t exp_res;
        exp_res = pending_results.pop_front();
        if (out_data.value_out !== exp_res.value_out ||
            out_data.on_outline !== exp_res.on_outline ||
            out_data.load_status !== exp_res.load_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h outline %b status %0d, got %h %b %0d",
                     exp_res.value_out, exp_res.on_outline, exp_res.load_status,
                     out_data.value_out, out_data.on_outline, out_data.load_status);
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    if (mismatches == 0 && pending_results.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/core/bboo_pkg.sv
rtl/core/bboo_ctrl.sv
rtl/core/bboo_dp.sv
rtl/core/bounding_box_outline_overlay.sv
tb/sv/bounding_box_outline_overlay_tb.sv
